// ----- src/crc32fc_pkg.sv -----
// Shared constants, types and functions for the CRC-32 frame checksum block.
// No dependencies. Imported by crc32fc_fold and crc32_frame_checksum.
`timescale 1ns / 1ps

package crc32fc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_ZERO = 32'h00000000;

    // Result convention selected by the mode register
    localparam logic MODE_INVERT = 1'b0;
    localparam logic MODE_SWAP   = 1'b1;

    // Per-byte control handed to the fold logic
    typedef struct packed {
        logic first;
        logic mode;
    } crc_ctrl_t;

    // Fold one byte into a reflected CRC-32, eight shift-xor steps
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc_in,
                                                  input logic [7:0]  data);
        logic [31:0] acc;
        acc = acc_in ^ {24'h000000, data};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    // Reverse the byte order of a word
    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ----- src/crc32fc_fold.sv -----
// Byte fold logic: start value selection, CRC-32 update and result formatting.
// Depends on crc32fc_pkg.
`timescale 1ns / 1ps

module crc32fc_fold
    import crc32fc_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_byte,
    input  crc_ctrl_t   ctrl,
    output logic [31:0] crc_out,
    output logic [31:0] checksum_out
);

    logic [31:0] start_value;
    logic [31:0] seed;

    // Pick the start value of the current convention on a first byte
    assign start_value = (ctrl.mode == MODE_SWAP) ? CRC_ZERO : CRC_ONES;
    assign seed        = ctrl.first ? start_value : crc_in;

    // Fold the byte
    assign crc_out = crc_fold_byte(seed, data_byte);

    // Format the finished value
    assign checksum_out = (ctrl.mode == MODE_SWAP) ? swap_bytes(crc_out) : ~crc_out;

endmodule

// ----- src/crc32_frame_checksum.sv -----
// Top level of the CRC-32 frame checksum block: input register, fold, result register.
// Depends on crc32fc_pkg and crc32fc_fold.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries data_byte, first_flag and
//   last_flag, one byte per transfer. A byte marked first restarts the
//   running CRC from the start value of the current mode; a byte marked
//   last produces one checksum transfer on the output channel
//   (out_valid / out_stall).
//   cfg_write_en / cfg_write_data write the mode register: 0 gives the
//   inverted CRC started from all ones, 1 gives the byte-swapped CRC
//   started from zero. Write it only while the block is idle.
//   Timing: a last byte is folded as it leaves the input register, which
//   loads its checksum into the result register and sets out_valid in the
//   same cycle. Throughput: one byte per cycle while the input does not
//   stall, set by the combinational eight-step byte fold between the input
//   register and the running CRC / result registers.
//   Reset clears both pipeline valids, sets the running CRC to all ones
//   and the mode to 0.
//   While the receiver stalls, the result register holds its checksum;
//   bytes that are not last keep flowing, and the input stalls only when
//   a last byte waits in the input register behind a held result.

module crc32_frame_checksum
    import crc32fc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_flag,
    input  logic        last_flag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] checksum
);

    logic        mode_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic [31:0] crc_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] checksum_reg;

    logic        out_free;
    logic        s1_advance;
    logic        emit;
    crc_ctrl_t   fold_ctrl;
    logic [31:0] crc_folded;
    logic [31:0] checksum_folded;

    // Handshake control
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign emit       = s1_advance && s1_last_reg;
    assign in_stall   = s1_valid_reg && !s1_advance;

    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Fold the staged byte
    assign fold_ctrl.first = s1_first_reg;
    assign fold_ctrl.mode  = mode_reg;

    crc32fc_fold u_fold (
        .crc_in       (crc_reg),
        .data_byte    (s1_byte_reg),
        .ctrl         (fold_ctrl),
        .crc_out      (crc_folded),
        .checksum_out (checksum_folded)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg      <= MODE_INVERT;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_ONES;
        end else begin
            if (cfg_write_en) begin
                mode_reg <= cfg_write_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance) begin
                crc_reg <= crc_folded;
            end
        end
    end

    // Capture the input transfer and load the result
    always_ff @(posedge clk) begin
        if (in_valid && !in_stall) begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_flag;
            s1_last_reg  <= last_flag;
        end
        if (emit) begin
            checksum_reg <= checksum_folded;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

    // Input stalls only behind a held result with a last byte staged
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid && out_stall))
        else $error("input stalled without a blocked last byte");

    // A last byte that leaves the input register shows a result next
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid)
        else $error("last byte left the input register without a result");

    // A taken result with nothing new behind it clears the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !emit) |=> !out_valid)
        else $error("result repeated after transfer");

    // Non-last bytes never stall the input
    a_no_stall_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_reg) |-> !in_stall)
        else $error("input stalled on a non-last byte");

endmodule
